FILE: design/fixed_point_alu_q24_8_assert.svh
// Assertion macros for the fixed-point ALU.
// Clocked on clk, disabled while rst_n is low; needs nothing else.
`ifndef FIXED_POINT_ALU_Q24_8_ASSERT_SVH
`define FIXED_POINT_ALU_Q24_8_ASSERT_SVH

// Check that pre implies post in the same cycle.
`define FPA_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("fpa assertion failed");

// Check that a condition never holds.
`define FPA_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("fpa assertion failed");

`endif

FILE: design/fpa_pkg.sv
// Shared types, opcodes and helpers for the fixed-point ALU.
// No dependencies.
package fpa_pkg;

    localparam int FRAC_BITS = 8;
    // Dividend is |a| scaled by 2^(FRAC_BITS+1) for round-to-nearest.
    localparam int DW = 33 + FRAC_BITS;
    localparam int FW = 32 + FRAC_BITS;

    typedef enum logic [3:0] {
        FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_GT, FN_LT, FN_GE, FN_LE,
        FN_EQ, FN_NE, FN_PREINC, FN_POSTINC, FN_PREDEC, FN_POSTDEC,
        FN_TOINT, FN_FROMINT
    } func_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    localparam logic [31:0] MAX32 = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN32 = 32'h8000_0000;

    typedef struct packed {
        func_t              func;
        logic signed [31:0] res;
        logic signed [31:0] upd;
        logic               cmp;
        logic [1:0]         st;
        logic signed [63:0] prod;
        logic               neg;
        logic               bzero;
        logic [DW-1:0]      qd;
        logic [32:0]        rem;
        logic [31:0]        dvs;
    } pipe_t;

    typedef struct packed {
        logic [1:0]  st;
        logic [31:0] res;
    } sat_t;

    // Clamp a signed magnitude to 32 bits.
    function automatic sat_t sat_mag(input logic neg, input logic [63:0] mag);
        sat_t r;
        r.st  = ST_OK;
        r.res = neg ? (32'd0 - mag[31:0]) : mag[31:0];
        if (!neg && mag > {32'd0, MAX32}) begin
            r.st  = ST_OVF;
            r.res = MAX32;
        end else if (neg && mag > {32'd0, MIN32}) begin
            r.st  = ST_OVF;
            r.res = MIN32;
        end
        return r;
    endfunction

endpackage

FILE: design/fpa_front.sv
// Entry stage: decode, simple operations, multiply, divider setup.
// Depends on fpa_pkg.
module fpa_front
    import fpa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [3:0]         func,
    input  logic signed [31:0] a_raw,
    input  logic signed [31:0] b_raw,
    output logic               valid_reg,
    output pipe_t              data_reg
);

    pipe_t              data_next;
    logic signed [32:0] sum;
    logic signed [32:0] dif;
    logic signed [FW-1:0] fi;
    logic [FW-32:0]     fi_hi;
    logic [31:0]        amag;
    logic [31:0]        bmag;

    // Compute simple results and operand magnitudes
    always_comb
    begin
        data_next       = '0;
        data_next.func  = func_t'(func);
        data_next.upd   = a_raw;
        data_next.st    = ST_OK;
        sum  = 33'(a_raw) + 33'(b_raw);
        dif  = 33'(a_raw) - 33'(b_raw);
        fi   = FW'(a_raw) <<< FRAC_BITS;
        fi_hi = fi[FW-1:31];
        amag = a_raw[31] ? (32'd0 - a_raw) : a_raw;
        bmag = b_raw[31] ? (32'd0 - b_raw) : b_raw;
        data_next.prod  = 64'(a_raw) * 64'(b_raw);
        data_next.neg   = a_raw[31] ^ b_raw[31];
        data_next.bzero = (b_raw == 32'sd0);
        data_next.qd    = {amag, {(FRAC_BITS + 1){1'b0}}};
        data_next.dvs   = bmag;
        case (func_t'(func))
            FN_ADD:
            begin
                data_next.res = sum[31:0];
                if (sum[32] != sum[31])
                begin
                    data_next.st  = ST_OVF;
                    data_next.res = sum[32] ? MIN32 : MAX32;
                end
            end
            FN_SUB:
            begin
                data_next.res = dif[31:0];
                if (dif[32] != dif[31])
                begin
                    data_next.st  = ST_OVF;
                    data_next.res = dif[32] ? MIN32 : MAX32;
                end
            end
            FN_GT: data_next.cmp = a_raw >  b_raw;
            FN_LT: data_next.cmp = a_raw <  b_raw;
            FN_GE: data_next.cmp = a_raw >= b_raw;
            FN_LE: data_next.cmp = a_raw <= b_raw;
            FN_EQ: data_next.cmp = a_raw == b_raw;
            FN_NE: data_next.cmp = a_raw != b_raw;
            FN_PREINC, FN_POSTINC:
            begin
                if (a_raw == MAX32)
                    data_next.st = ST_OVF;
                else
                    data_next.upd = a_raw + 32'sd1;
                data_next.res = (func_t'(func) == FN_PREINC) ? data_next.upd : a_raw;
            end
            FN_PREDEC, FN_POSTDEC:
            begin
                if (a_raw == MIN32)
                    data_next.st = ST_OVF;
                else
                    data_next.upd = a_raw - 32'sd1;
                data_next.res = (func_t'(func) == FN_PREDEC) ? data_next.upd : a_raw;
            end
            FN_TOINT: data_next.res = a_raw >>> FRAC_BITS;
            FN_FROMINT:
            begin
                data_next.res = fi[31:0];
                if (!(&fi_hi) && (|fi_hi))
                begin
                    data_next.st  = ST_OVF;
                    data_next.res = a_raw[31] ? MIN32 : MAX32;
                end
            end
            default: ;
        endcase
    end

    // Advance the entry stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

endmodule

FILE: design/fpa_div_stage.sv
// One restoring-division step: one quotient bit per stage.
// Depends on fpa_pkg.
module fpa_div_stage
    import fpa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  valid_in,
    input  pipe_t data_in,
    output logic  valid_reg,
    output pipe_t data_reg
);

    pipe_t       data_next;
    logic [32:0] sh;
    logic        take;

    // Shift in the next dividend bit and try a subtract
    always_comb
    begin
        data_next = data_in;
        sh   = {data_in.rem[31:0], data_in.qd[DW-1]};
        take = sh >= {1'b0, data_in.dvs};
        data_next.rem = take ? (sh - {1'b0, data_in.dvs}) : sh;
        data_next.qd  = {data_in.qd[DW-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

endmodule

FILE: design/fpa_back.sv
// Exit stage: rounding and saturation of mul and div, output registers.
// Depends on fpa_pkg.
module fpa_back
    import fpa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               valid_in,
    input  pipe_t              data_in,
    output logic               out_valid,
    output logic signed [31:0] result_raw,
    output logic signed [31:0] updated_a,
    output logic               compare_true,
    output logic [1:0]         status
);

    logic        valid_reg;
    logic [31:0] res_reg;
    logic [31:0] upd_reg;
    logic        cmp_reg;
    logic [1:0]  st_reg;
    logic [31:0] res_next;
    logic [1:0]  st_next;
    logic [63:0] pmag;
    logic [63:0] mmag;
    logic [DW-1:0] q;
    sat_t        s;

    localparam logic [63:0] HALF = 64'((64'd1 << FRAC_BITS) >> 1);

    // Round and clamp the long results
    always_comb
    begin
        res_next = data_in.res;
        st_next  = data_in.st;
        pmag = data_in.prod[63] ? (64'd0 - data_in.prod) : data_in.prod;
        mmag = (pmag + HALF) >> FRAC_BITS;
        q    = (data_in.qd + DW'(1)) >> 1;
        s    = sat_mag(1'b0, 64'd0);
        case (data_in.func)
            FN_MUL:
            begin
                s = sat_mag(data_in.prod[63], mmag);
                res_next = s.res;
                st_next  = s.st;
            end
            FN_DIV:
            begin
                s = sat_mag(data_in.neg, 64'(q));
                res_next = s.res;
                st_next  = s.st;
                if (data_in.bzero)
                begin
                    res_next = 32'd0;
                    st_next  = ST_DIVZ;
                end
            end
            default: ;
        endcase
    end

    // Hold the result beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
            upd_reg <= data_in.upd;
            cmp_reg <= data_in.cmp;
            st_reg  <= st_next;
        end
    end

    assign out_valid    = valid_reg;
    assign result_raw   = res_reg;
    assign updated_a    = upd_reg;
    assign compare_true = cmp_reg;
    assign status       = st_reg;

endmodule

FILE: design/fixed_point_alu_q24_8.sv
// Channel | signals                                         | role
// input   | in_valid, in_ready, func, a_raw, b_raw          | one operation per beat
// output  | out_valid, out_ready, result_raw, updated_a,    | one result per beat
//         | compare_true, status                            |
// Every result passes the entry register, the division chain of one quotient bit
// per stage and the exit register; every opcode takes the same path, so order holds.
// One beat is accepted per cycle. The whole pipeline advances together when the
// output is empty or taken; a stall freezes every stage. Reset clears valid bits.
// Depends on fpa_pkg, fpa_front, fpa_div_stage, fpa_back and the assert header.
`include "fixed_point_alu_q24_8_assert.svh"
module fixed_point_alu_q24_8
    import fpa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         func,
    input  logic signed [31:0] a_raw,
    input  logic signed [31:0] b_raw,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] result_raw,
    output logic signed [31:0] updated_a,
    output logic               compare_true,
    output logic [1:0]         status
);

    logic        en;
    logic [DW:0] vld;
    pipe_t       dat [DW+1];

    // Advance all stages when the output slot frees up
    assign en       = out_ready || !out_valid;
    assign in_ready = en;

    fpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .func      (func),
        .a_raw     (a_raw),
        .b_raw     (b_raw),
        .valid_reg (vld[0]),
        .data_reg  (dat[0])
    );

    for (genvar k = 0; k < DW; k++)
    begin : g_div
        fpa_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (vld[k]),
            .data_in   (dat[k]),
            .valid_reg (vld[k+1]),
            .data_reg  (dat[k+1])
        );
    end

    fpa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .valid_in     (vld[DW]),
        .data_in      (dat[DW]),
        .out_valid    (out_valid),
        .result_raw   (result_raw),
        .updated_a    (updated_a),
        .compare_true (compare_true),
        .status       (status)
    );

    `FPA_ASSERT_IMPL(a_divz_zero, out_valid && status == ST_DIVZ, result_raw == 32'd0)
    `FPA_ASSERT_IMPL(a_cmp_clean, out_valid && compare_true, status == ST_OK && result_raw == 32'd0)
    `FPA_ASSERT_NEVER(a_st_code, out_valid && status == 2'd3)
    `FPA_ASSERT_IMPL(a_stall_hold, out_valid && !out_ready, !in_ready)

endmodule

FILE: sim/fixed_point_alu_q24_8_tb.sv
// Testbench for the Q24.8 fixed-point ALU: directed corners, then random beats.
// Predicts each result in the bench and checks it in order; depends on fpa_pkg.
module fixed_point_alu_q24_8_tb;
    import fpa_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [3:0]         func;
    logic signed [31:0] a_raw;
    logic signed [31:0] b_raw;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] result_raw;
    logic signed [31:0] updated_a;
    logic               compare_true;
    logic [1:0]         status;

    typedef struct packed {
        logic [31:0] res;
        logic [31:0] upd;
        logic        cmp;
        logic [1:0]  st;
    } alu_out_t;

    alu_out_t expected_q[$];
    int       errors;
    int       idle_cycles;
    int       send_idle_pct;
    int       recv_stall_pct;
    int       hold_off;

    fixed_point_alu_q24_8 DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .a_raw(a_raw), .b_raw(b_raw),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_raw(result_raw), .updated_a(updated_a),
        .compare_true(compare_true), .status(status)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Clamp a wide signed value to 32 bits, flagging overflow.
    function automatic logic [31:0] clamp32(input logic signed [95:0] v,
                                            inout logic [1:0] st);
        if (v > 96'sh7FFF_FFFF)
        begin
            st = ST_OVF;
            return MAX32;
        end
        if (v < -96'sh8000_0000)
        begin
            st = ST_OVF;
            return MIN32;
        end
        return v[31:0];
    endfunction

    function automatic alu_out_t alu_predict(input logic [3:0] fn,
                                             input logic signed [31:0] a,
                                             input logic signed [31:0] b);
        alu_out_t r;
        logic signed [95:0] wa;
        logic signed [95:0] wb;
        logic signed [95:0] p;
        logic [95:0]        m;
        logic [95:0]        na;
        logic [95:0]        nb;
        logic [1:0]         st;
        wa = a;
        wb = b;
        st = ST_OK;
        r.res = '0;
        r.upd = a;
        r.cmp = 1'b0;
        case (func_t'(fn))
            FN_ADD: r.res = clamp32(wa + wb, st);
            FN_SUB: r.res = clamp32(wa - wb, st);
            FN_MUL:
            begin
                p = wa * wb;
                m = ((p < 0 ? -p : p) + (96'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                r.res = clamp32(p < 0 ? -$signed(m) : $signed(m), st);
            end
            FN_DIV:
            begin
                if (b == 0)
                    st = ST_DIVZ;
                else
                begin
                    na = (wa < 0 ? -wa : wa) << FRAC_BITS;
                    nb = wb < 0 ? -wb : wb;
                    m = (2 * na + nb) / (2 * nb);
                    r.res = clamp32(((a < 0) != (b < 0)) ? -$signed(m) : $signed(m), st);
                end
            end
            FN_GT: r.cmp = a > b;
            FN_LT: r.cmp = a < b;
            FN_GE: r.cmp = a >= b;
            FN_LE: r.cmp = a <= b;
            FN_EQ: r.cmp = a == b;
            FN_NE: r.cmp = a != b;
            FN_PREINC:
            begin
                r.upd = clamp32(wa + 1, st);
                r.res = r.upd;
            end
            FN_POSTINC:
            begin
                r.upd = clamp32(wa + 1, st);
                r.res = a;
            end
            FN_PREDEC:
            begin
                r.upd = clamp32(wa - 1, st);
                r.res = r.upd;
            end
            FN_POSTDEC:
            begin
                r.upd = clamp32(wa - 1, st);
                r.res = a;
            end
            FN_TOINT: r.res = a >>> FRAC_BITS;
            default: r.res = clamp32(wa <<< FRAC_BITS, st);
        endcase
        r.st = st;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Send one beat: optional idle gap, then hold valid until accepted.
    // Valid stays high on return so the next beat can follow directly.
    task automatic send_op(input logic [3:0] fn, input logic [31:0] a,
                           input logic [31:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= fn;
        a_raw    <= a;
        b_raw    <= b;
        expected_q.push_back(alu_predict(fn, a, b));
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drive ready each cycle; a pending hold-off keeps it low.
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            out_ready <= 1'b0;
            hold_off  <= hold_off - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check each result beat against the oldest prediction.
    always @(posedge clk)
    begin
        alu_out_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected beat", result_raw, 32'd0);
            else
            begin
                w = expected_q.pop_front();
                if (result_raw !== w.res)
                    report_mismatch("result_raw", result_raw, w.res);
                if (updated_a !== w.upd)
                    report_mismatch("updated_a", updated_a, w.upd);
                if (compare_true !== w.cmp)
                    report_mismatch("compare_true", compare_true, w.cmp);
                if (status !== w.st)
                    report_mismatch("status", status, w.st);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5))
            0: return $urandom_range(2047) - 1024;
            1: return $urandom_range(65535) - 32768;
            2: return $urandom_range(3) == 0 ? 32'h7FFF_FFFF - $urandom_range(3)
                                             : 32'h8000_0000 + $urandom_range(3);
            3: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // Drop valid and wait until every expected beat has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_corners();
        logic [31:0] vals[6];
        vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h100, 32'h80};
        for (int f = 0; f < 16; f++)
            send_op(f[3:0], vals[f % 6], vals[(f + 1) % 6]);
        send_op(FN_DIV, 32'h100, 32'h0);
        send_op(FN_DIV, 32'h7FFF_FFFF, 32'h1);
        send_op(FN_MUL, 32'h7FFF_FFFF, 32'h8000_0000);
        send_op(FN_MUL, 32'h180, 32'hFFFF_FF01);
        send_op(FN_PREINC, 32'h7FFF_FFFF, 32'h0);
        send_op(FN_POSTDEC, 32'h8000_0000, 32'h0);
        send_op(FN_TOINT, 32'hFFFF_FFFF, 32'h0);
        send_op(FN_EQ, 32'h5, 32'h5);
        drain();
    endtask

    task automatic test_random(input int n, input int s_pct, input int r_pct);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        for (int i = 0; i < n; i++)
            send_op(4'($urandom), rand_operand(), rand_operand());
    endtask

    // Hold the output off long enough that the pipeline fills and stalls input.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off       = 150;
        for (int i = 0; i < 80; i++)
            send_op(4'($urandom), rand_operand(), rand_operand());
        drain();
    endtask

    initial
    begin
        errors         = 0;
        idle_cycles    = 0;
        hold_off       = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        out_ready      = 1'b0;
        func           = '0;
        a_raw          = '0;
        b_raw          = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corners();
        test_random(250, 0, 0);
        test_random(220, 68, 0);
        test_random(220, 0, 68);
        test_backpressure();
        test_random(250, 10, 10);
        drain();
        repeat (60) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
